### rtl/core/adgrb_pkg.sv
// Shared types and constants for the audio downmix, gain and ring buffer block.
package adgrb_pkg;

   // Request modes
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_PULL  = 2'd1;
   localparam logic [1:0] MODE_BEGIN = 2'd2;
   localparam logic [1:0] MODE_END   = 2'd3;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_CHANNELS = 2'd0;
   localparam logic [1:0] REG_RATE     = 2'd1;
   localparam logic [1:0] REG_GAIN     = 2'd2;

   // Register reset values
   localparam logic [3:0]  CHANNELS_RST = 4'd1;
   localparam logic [17:0] RATE_RST     = 18'd48000;
   localparam logic [14:0] GAIN_RST     = 15'd4096;

   // Preroll: max(rate / 12, 160); rate / 12 is (rate >> 2) * 43691 >> 17
   localparam logic [17:0] DEFAULT_RATE = 18'd48000;
   localparam logic [15:0] MIN_PREROLL  = 16'd160;
   localparam logic [15:0] RECIP_THREE  = 16'd43691;
   localparam int          RECIP_SHIFT  = 17;

   // Downmix sum magnitude width (eight full-scale samples)
   localparam int DIV_BITS = 19;

   // Rounding and saturation of the scaled sample
   localparam logic [31:0] ROUND_HALF = 32'd2048;
   localparam logic [20:0] SAT_POS    = 21'd32767;
   localparam logic [20:0] SAT_NEG    = 21'd32768;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] sample_0;
      logic signed [15:0] sample_1;
      logic signed [15:0] sample_2;
      logic signed [15:0] sample_3;
      logic signed [15:0] sample_4;
      logic signed [15:0] sample_5;
      logic signed [15:0] sample_6;
      logic signed [15:0] sample_7;
      logic [6:0]         max_samples;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic               valid_res;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  channel_count;
      logic [17:0] sample_rate;
      logic [14:0] gain_q;
   } cfg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_req;
      logic       begin_sess;
      logic       end_sess;
      logic       sum_step;
      logic [2:0] step_idx;
      logic       div_init;
      logic       div_step;
      logic       mul;
      logic       scale;
      logic       pre;
      logic       gen;
      logic       clamp;
      logic       ovr;
      logic       dist_load;
      logic       avail;
      logic       rd_issue;
      logic       out_data;
      logic       out_empty;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [1:0] mode;
      logic       live;
      logic [3:0] nch;
      logic       wc_zero;
      logic       limit_zero;
      logic       avail_zero;
      logic       cnt_one;
      logic       out_free;
   } sts_type;

endpackage

### rtl/core/audio_downmix_gain_ring_buffer.sv
// Top level: configuration registers, controller and datapath of the audio ring buffer.
//
// Usage: request beats on req_* carry a mode and an interleaved frame. A push
// downmixes the active channels, applies the Q3.12 gain and appends one sample
// to the ring while a session is live. Begin and end sessions switch the live
// flag. A pull returns 1 to max_samples beats on rsp_*, the final one marked
// by last; an empty pull returns one beat with valid_res low.
// Sequence, from one accepted request to the next: a push sums the channels and,
// when mixing, divides through the one-bit-a-cycle divider before gain and write.
// A dropped push, begin and end go back to idle after dispatch. A pull sets up
// its cursor, then reads each sample through the ring read port and result
// register, waiting on any receiver stall.
// The block takes one request at a time; req_stall is high while it works.
// The result register keeps a beat until rsp_stall is low, so a new request
// may be taken while the final beat still waits.
// Reset clears the write count, generations, live flag and reader cursor and
// loads the register defaults; ring contents are undefined until written.
// Registers: channel_count at 0x0, sample_rate at 0x4, gain_q at 0x8.
module audio_downmix_gain_ring_buffer #(
   parameter int RING_DEPTH   = 65536,
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_PULL     = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  adgrb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output adgrb_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   adgrb_pkg::cfg_type cfg_ff;
   adgrb_pkg::cmd_type cmd;
   adgrb_pkg::sts_type sts;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= adgrb_pkg::CHANNELS_RST;
         cfg_ff.sample_rate   <= adgrb_pkg::RATE_RST;
         cfg_ff.gain_q        <= adgrb_pkg::GAIN_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            adgrb_pkg::REG_CHANNELS: cfg_ff.channel_count <= csr_pwdata[3:0];
            adgrb_pkg::REG_RATE:     cfg_ff.sample_rate   <= csr_pwdata[17:0];
            adgrb_pkg::REG_GAIN:     cfg_ff.gain_q        <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Register read back
   always_comb begin
      unique case (csr_paddr[3:2])
         adgrb_pkg::REG_CHANNELS: csr_prdata = {28'd0, cfg_ff.channel_count};
         adgrb_pkg::REG_RATE:     csr_prdata = {14'd0, cfg_ff.sample_rate};
         adgrb_pkg::REG_GAIN:     csr_prdata = {17'd0, cfg_ff.gain_q};
         default:                 csr_prdata = '0;
      endcase
   end

   adgrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   adgrb_dpath #(
      .RING_DEPTH   (RING_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_PULL     (MAX_PULL)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/adgrb_ctrl.sv
// Controller state machine that sequences pushes, pulls and session changes.
module adgrb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  adgrb_pkg::sts_type sts,
   output adgrb_pkg::cmd_type cmd
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000_0000_0000_0001,
      S_DISP  = 16'b0000_0000_0000_0010,
      S_SUM   = 16'b0000_0000_0000_0100,
      S_DINIT = 16'b0000_0000_0000_1000,
      S_DIV   = 16'b0000_0000_0001_0000,
      S_MUL   = 16'b0000_0000_0010_0000,
      S_SCALE = 16'b0000_0000_0100_0000,
      S_PRE   = 16'b0000_0000_1000_0000,
      S_GEN   = 16'b0000_0001_0000_0000,
      S_CLAMP = 16'b0000_0010_0000_0000,
      S_OVR   = 16'b0000_0100_0000_0000,
      S_DIST  = 16'b0000_1000_0000_0000,
      S_AVAIL = 16'b0001_0000_0000_0000,
      S_RD    = 16'b0010_0000_0000_0000,
      S_LD    = 16'b0100_0000_0000_0000,
      S_EMPTY = 16'b1000_0000_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;

   // Only an idle controller takes a new request beat.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step_idx = step_ff[2:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            step_in = '0;
            unique case (sts.mode)
               adgrb_pkg::MODE_PUSH:  state_in = sts.live ? S_SUM : S_IDLE;
               adgrb_pkg::MODE_PULL:
                  state_in = (sts.limit_zero || sts.wc_zero) ? S_EMPTY : S_PRE;
               adgrb_pkg::MODE_BEGIN: begin
                  cmd.begin_sess = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  cmd.end_sess = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (step_ff == {1'b0, sts.nch - 4'd1}) begin
               step_in  = '0;
               state_in = (sts.nch == 4'd1) ? S_MUL : S_DINIT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == 5'(adgrb_pkg::DIV_BITS - 1)) begin
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_IDLE;
         end
         S_PRE: begin
            cmd.pre  = 1'b1;
            state_in = S_GEN;
         end
         S_GEN: begin
            cmd.gen  = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_OVR;
         end
         S_OVR: begin
            cmd.ovr  = 1'b1;
            state_in = S_DIST;
         end
         S_DIST: begin
            cmd.dist_load = 1'b1;
            state_in = S_AVAIL;
         end
         S_AVAIL: begin
            cmd.avail = 1'b1;
            state_in  = sts.avail_zero ? S_EMPTY : S_RD;
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_LD;
         end
         S_LD: begin
            if (sts.out_free) begin
               cmd.out_data = 1'b1;
               state_in = sts.cnt_one ? S_IDLE : S_RD;
            end
         end
         S_EMPTY: begin
            if (sts.out_free) begin
               cmd.out_empty = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // A sample beat is only loaded after its ring read, once the result register is free.
   a_ld_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.out_data |-> $past(cmd.rd_issue) || $past(state_ff == S_LD))
      else $error("sample beat loaded without a ring read");

   // The scale step, which writes the push result, always follows the multiply step.
   a_scale_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.scale)
      else $error("scale step did not follow multiply");

   // An accepted request beat is dispatched in the next cycle.
   a_disp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> state_ff == S_DISP)
      else $error("accepted request not dispatched");

endmodule

### rtl/core/adgrb_dpath.sv
// Datapath: downmix, divide, gain, ring memory, reader cursor and result register.
module adgrb_dpath #(
   parameter int RING_DEPTH   = 65536,
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_PULL     = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  adgrb_pkg::req_type req_data,
   input  adgrb_pkg::cfg_type cfg,
   input  adgrb_pkg::cmd_type cmd,
   output adgrb_pkg::sts_type sts,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output adgrb_pkg::rsp_type rsp_data
);

   localparam int          AW        = $clog2(RING_DEPTH);
   localparam int          DW        = $clog2(RING_DEPTH + 1);
   localparam logic [63:0] DEPTH64   = 64'(RING_DEPTH);
   localparam logic [63:0] QUARTER64 = 64'(RING_DEPTH / 4);
   localparam logic [DW-1:0] DEPTH_DW = DW'(RING_DEPTH);
   localparam logic [3:0]  MAXCH     = 4'(MAX_CHANNELS);
   localparam logic [6:0]  MAXPULL   = 7'(MAX_PULL);

   // Latched request
   adgrb_pkg::req_type req_ff;
   logic [6:0]         limit_ff;

   // Downmix accumulator and shift divider
   logic signed [19:0] acc_ff;
   logic               neg_ff;
   logic [18:0]        quo_ff;
   logic [3:0]         rem_ff;
   logic signed [31:0] prod_ff;

   // Writer and session state
   logic [63:0]   wc_ff;
   logic [AW-1:0] wr_idx_ff;
   logic          live_ff;
   logic [31:0]   sgen_ff;

   // Reader state
   logic [63:0]   rpos_ff;
   logic [31:0]   rgen_ff;
   logic [15:0]   preroll_ff;
   logic [DW-1:0] dist_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [6:0]    cnt_ff;

   // Ring memory and its registered read
   logic [15:0] ring_mem [RING_DEPTH];
   logic [15:0] rd_data_ff;

   // Result register
   logic               out_valid_ff;
   adgrb_pkg::rsp_type out_ff;

   // Effective channel count, 1 to MAX_CHANNELS
   logic [3:0] nch_sat, nch;
   assign nch_sat = (cfg.channel_count > MAXCH) ? MAXCH : cfg.channel_count;
   assign nch     = (nch_sat == 4'd0) ? 4'd1 : nch_sat;

   // Sample selected for the current sum step
   logic signed [15:0] samp_sel;
   always_comb begin
      unique case (cmd.step_idx)
         3'd0: samp_sel = req_ff.sample_0;
         3'd1: samp_sel = req_ff.sample_1;
         3'd2: samp_sel = req_ff.sample_2;
         3'd3: samp_sel = req_ff.sample_3;
         3'd4: samp_sel = req_ff.sample_4;
         3'd5: samp_sel = req_ff.sample_5;
         3'd6: samp_sel = req_ff.sample_6;
         default: samp_sel = req_ff.sample_7;
      endcase
   end

   // One restoring divide step on the sum magnitude
   logic [4:0] div_t;
   logic       div_ge;
   assign div_t  = {rem_ff, quo_ff[18]};
   assign div_ge = (div_t >= {1'b0, nch});

   // Mix and gain multiply
   logic signed [16:0] mix;
   logic [16:0]        quo_s;
   logic signed [32:0] prod_full;
   assign quo_s     = neg_ff ? (17'd0 - quo_ff[16:0]) : quo_ff[16:0];
   assign mix       = (nch == 4'd1) ? acc_ff[16:0] : $signed(quo_s);
   assign prod_full = mix * $signed({1'b0, cfg.gain_q});

   // Round half away from zero and saturate
   logic        pneg;
   logic [31:0] pmag, psum;
   logic [20:0] rnd;
   logic [15:0] scaled;
   assign pneg = prod_ff[31];
   assign pmag = pneg ? (32'd0 - prod_ff) : prod_ff;
   assign psum = pmag + adgrb_pkg::ROUND_HALF;
   assign rnd  = {1'b0, psum[31:12]};
   always_comb begin
      if (!pneg) begin
         scaled = (rnd > adgrb_pkg::SAT_POS) ? 16'h7fff : rnd[15:0];
      end else begin
         scaled = (rnd > adgrb_pkg::SAT_NEG) ? 16'h8000 : (16'd0 - rnd[15:0]);
      end
   end

   // Preroll from the rate register
   logic [17:0] rate_eff;
   logic [31:0] third;
   logic [15:0] preroll_c;
   assign rate_eff  = (cfg.sample_rate == 18'd0) ? adgrb_pkg::DEFAULT_RATE : cfg.sample_rate;
   assign third     = rate_eff[17:2] * adgrb_pkg::RECIP_THREE;
   assign preroll_c = ((third >> adgrb_pkg::RECIP_SHIFT) < 32'(adgrb_pkg::MIN_PREROLL)) ?
                      adgrb_pkg::MIN_PREROLL : 16'(third >> adgrb_pkg::RECIP_SHIFT);

   // Reader arithmetic
   logic [63:0]   back_pos, wdist;
   logic [DW-1:0] wr_dw;
   logic [6:0]    avail_c;
   logic [AW-1:0] rd_start;
   assign back_pos = wc_ff - {48'd0, preroll_ff};
   assign wdist    = wc_ff - rpos_ff;
   assign wr_dw    = DW'(wr_idx_ff);
   assign avail_c  = (dist_ff < DW'(limit_ff)) ? 7'(dist_ff) : limit_ff;
   assign rd_start = (wr_dw >= dist_ff) ? AW'(wr_dw - dist_ff)
                                        : AW'(wr_dw + DEPTH_DW - dist_ff);

   logic out_free;
   assign out_free = !out_valid_ff || !rsp_stall;

   // Request latch and push arithmetic
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff   <= req_data;
         limit_ff <= (req_data.max_samples > MAXPULL) ? MAXPULL : req_data.max_samples;
         acc_ff   <= '0;
      end else if (cmd.sum_step) begin
         acc_ff <= acc_ff + 20'(samp_sel);
      end
      if (cmd.div_init) begin
         neg_ff <= acc_ff[19];
         quo_ff <= acc_ff[19] ? 19'(20'd0 - acc_ff) : acc_ff[18:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? 4'(div_t - {1'b0, nch}) : div_t[3:0];
         quo_ff <= {quo_ff[17:0], div_ge};
      end
      if (cmd.mul) begin
         prod_ff <= prod_full[31:0];
      end
      if (cmd.pre) begin
         preroll_ff <= preroll_c;
      end
      if (cmd.dist_load) begin
         dist_ff <= DW'(wdist);
      end
   end

   // Ring memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         ring_mem[wr_idx_ff] <= scaled;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= ring_mem[rd_idx_ff];
      end
   end

   // Writer, session and reader control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff     <= '0;
         wr_idx_ff <= '0;
         live_ff   <= 1'b0;
         sgen_ff   <= '0;
         rpos_ff   <= '0;
         rgen_ff   <= '0;
         rd_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.begin_sess) begin
            wc_ff     <= '0;
            wr_idx_ff <= '0;
            live_ff   <= 1'b1;
            sgen_ff   <= sgen_ff + 32'd1;
         end else if (cmd.end_sess) begin
            live_ff <= 1'b0;
            sgen_ff <= sgen_ff + 32'd1;
         end else if (cmd.scale) begin
            wc_ff     <= wc_ff + 64'd1;
            wr_idx_ff <= (wr_idx_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_idx_ff + AW'(1);
         end
         if (cmd.gen && (rgen_ff != sgen_ff)) begin
            rgen_ff <= sgen_ff;
            rpos_ff <= (wc_ff > {48'd0, preroll_ff}) ? back_pos : 64'd0;
         end else if (cmd.clamp && (rpos_ff > wc_ff)) begin
            rpos_ff <= wc_ff;
         end else if (cmd.ovr && (wdist > DEPTH64)) begin
            rpos_ff <= wc_ff - QUARTER64;
         end else if (cmd.avail) begin
            rpos_ff <= rpos_ff + 64'(avail_c);
         end
         if (cmd.avail) begin
            cnt_ff    <= avail_c;
            rd_idx_ff <= rd_start;
         end else if (cmd.rd_issue) begin
            rd_idx_ff <= (rd_idx_ff == AW'(RING_DEPTH - 1)) ? '0 : rd_idx_ff + AW'(1);
         end else if (cmd.out_data) begin
            cnt_ff <= cnt_ff - 7'd1;
         end
      end
   end

   // Result register: holds its beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_data || cmd.out_empty) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_data) begin
         out_ff.sample_value <= rd_data_ff;
         out_ff.valid_res    <= 1'b1;
         out_ff.last         <= (cnt_ff == 7'd1);
      end else if (cmd.out_empty) begin
         out_ff.sample_value <= '0;
         out_ff.valid_res    <= 1'b0;
         out_ff.last         <= 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Status to the controller
   assign sts.mode       = req_ff.mode;
   assign sts.live       = live_ff;
   assign sts.nch        = nch;
   assign sts.wc_zero    = (wc_ff == 64'd0);
   assign sts.limit_zero = (limit_ff == 7'd0);
   assign sts.avail_zero = (dist_ff == '0);
   assign sts.cnt_one    = (cnt_ff == 7'd1);
   assign sts.out_free   = out_free;

   a_write_live: assert property (@(posedge clock) disable iff (reset)
      cmd.scale |-> live_ff)
      else $error("ring written outside a live session");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> cnt_ff != 7'd0)
      else $error("ring read with no samples left");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_data || cmd.out_empty) |-> out_free)
      else $error("result beat overwritten before it was taken");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.avail |-> dist_ff <= DEPTH_DW)
      else $error("reader distance exceeds ring depth");

endmodule
